>>> src/kpe_pkg.sv
// Shared types and constants of the key data PMKID extractor.
package kpe_pkg;

  // Parse phase of the element walker.
  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgKdeType       = 2'd0;
  localparam logic [1:0] CfgKdeOui        = 2'd1;
  localparam logic [1:0] CfgPmkidDataType = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  KdeTypeReset       = 8'hDD;
  localparam logic [23:0] KdeOuiReset        = 24'h000FAC;
  localparam logic [7:0]  PmkidDataTypeReset = 8'h04;

  // Element layout.
  localparam logic [7:0] MinKdeLen    = 8'd20;
  localparam logic [7:0] PosOuiHi     = 8'd0;
  localparam logic [7:0] PosOuiMid    = 8'd1;
  localparam logic [7:0] PosOuiLo     = 8'd2;
  localparam logic [7:0] PosDataType  = 8'd3;
  localparam logic [7:0] PmkidFirst   = 8'd4;
  localparam logic [7:0] PmkidSecond  = 8'd12;
  localparam logic [7:0] PmkidEnd     = 8'd20;

  localparam logic [11:0] CountMax = 12'd4095;

  // Queue between parser and output stage.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // Outcome of one parsed byte: a PMKID, a summary, or both.
  typedef struct packed {
    logic        pmkid_valid;
    logic        summary_valid;
    logic [63:0] upper;
    logic [63:0] lower;
    logic [11:0] count;
    logic        truncated;
  } q_entry_t;

endpackage

>>> src/kpe_front.sv
// Byte parser: configuration registers, element walker and PMKID capture.
module kpe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                key_data_encrypted_i,
  input  logic                q_full_i,
  output logic                push_o,
  output kpe_pkg::q_entry_t   entry_o
);

  logic [7:0]  kde_type_q;
  logic [23:0] kde_oui_q;
  logic [7:0]  pmkid_type_q;

  kpe_pkg::phase_e phase_q, phase_d;
  logic [7:0]  etype_q, etype_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic        hm_q, hm_d;
  logic [63:0] store_hi_q, store_hi_d;
  logic [63:0] store_lo_q, store_lo_d;
  logic [11:0] cnt_q, cnt_d;

  logic        accept;
  logic [8:0]  pos_inc;
  logic        body_done;
  logic        hm_next;
  logic        complete;
  logic        pmkid_hit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~q_full_i;
  assign accept      = in_valid_i & ~q_full_i;
  assign pos_inc     = {1'b0, pos_q} + 9'd1;
  assign body_done   = pos_inc >= {1'b0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kde_type_q   <= kpe_pkg::KdeTypeReset;
      kde_oui_q    <= kpe_pkg::KdeOuiReset;
      pmkid_type_q <= kpe_pkg::PmkidDataTypeReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kpe_pkg::CfgKdeType:       kde_type_q   <= cfg_data_i[7:0];
        kpe_pkg::CfgKdeOui:        kde_oui_q    <= cfg_data_i;
        kpe_pkg::CfgPmkidDataType: pmkid_type_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      kpe_pkg::PH_TYPE:   phase_d = kpe_pkg::PH_LENGTH;
      kpe_pkg::PH_LENGTH: phase_d = (data_byte_i == 8'd0) ? kpe_pkg::PH_TYPE
                                                          : kpe_pkg::PH_BODY;
      kpe_pkg::PH_BODY:   phase_d = body_done ? kpe_pkg::PH_TYPE : kpe_pkg::PH_BODY;
      default:            phase_d = kpe_pkg::PH_TYPE;
    endcase
    if (last_byte_i) begin
      phase_d = kpe_pkg::PH_TYPE;
    end
  end

  // Element fields, header match, PMKID capture and the queue entry.
  always_comb begin
    etype_d    = etype_q;
    len_d      = len_q;
    pos_d      = pos_q;
    hm_d       = hm_q;
    hm_next    = hm_q;
    store_hi_d = store_hi_q;
    store_lo_d = store_lo_q;
    complete   = 1'b0;
    pmkid_hit  = 1'b0;
    case (phase_q)
      kpe_pkg::PH_TYPE: begin
        etype_d  = data_byte_i;
        complete = 1'b1;
      end
      kpe_pkg::PH_LENGTH: begin
        len_d    = data_byte_i;
        pos_d    = 8'd0;
        hm_d     = (etype_q == kde_type_q) && (data_byte_i >= kpe_pkg::MinKdeLen);
        complete = (data_byte_i == 8'd0);
      end
      kpe_pkg::PH_BODY: begin
        case (pos_q)
          kpe_pkg::PosOuiHi:    hm_next = hm_q && (data_byte_i == kde_oui_q[23:16]);
          kpe_pkg::PosOuiMid:   hm_next = hm_q && (data_byte_i == kde_oui_q[15:8]);
          kpe_pkg::PosOuiLo:    hm_next = hm_q && (data_byte_i == kde_oui_q[7:0]);
          kpe_pkg::PosDataType: hm_next = hm_q && (data_byte_i == pmkid_type_q);
          default: begin
            hm_next = hm_q;
            if (hm_q && (pos_q < kpe_pkg::PmkidEnd)) begin
              if (pos_q < kpe_pkg::PmkidSecond) begin
                store_hi_d = {store_hi_q[55:0], data_byte_i};
              end else begin
                store_lo_d = {store_lo_q[55:0], data_byte_i};
              end
            end
          end
        endcase
        pos_d = pos_inc[7:0];
        if (body_done) begin
          complete  = 1'b1;
          pmkid_hit = hm_next && !key_data_encrypted_i;
          hm_d      = 1'b0;
        end else begin
          hm_d = hm_next;
        end
      end
      default: ;
    endcase

    cnt_d = (pmkid_hit && (cnt_q != kpe_pkg::CountMax)) ? cnt_q + 12'd1 : cnt_q;

    entry_o.pmkid_valid   = pmkid_hit;
    entry_o.summary_valid = last_byte_i;
    entry_o.upper         = store_hi_d;
    entry_o.lower         = store_lo_d;
    entry_o.count         = (last_byte_i && key_data_encrypted_i) ? 12'd0 : cnt_d;
    entry_o.truncated     = last_byte_i && !key_data_encrypted_i && !complete;

    if (last_byte_i) begin
      etype_d = 8'd0;
      len_d   = 8'd0;
      pos_d   = 8'd0;
      hm_d    = 1'b0;
      cnt_d   = 12'd0;
    end
  end

  assign push_o = accept && (pmkid_hit || last_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpe_pkg::PH_TYPE;
      etype_q <= 8'd0;
      len_q   <= 8'd0;
      pos_q   <= 8'd0;
      hm_q    <= 1'b0;
      cnt_q   <= 12'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      etype_q <= etype_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      hm_q    <= hm_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_hi_q <= store_hi_d;
      store_lo_q <= store_lo_d;
    end
  end

endmodule

>>> src/kpe_queue.sv
// Small FIFO of parse outcomes between the parser and the output stage.
module kpe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kpe_pkg::q_entry_t  entry_i,
  output logic               full_o,
  output logic               valid_o,
  output kpe_pkg::q_entry_t  head_o,
  input  logic               pop_i
);

  kpe_pkg::q_entry_t          mem_q [kpe_pkg::QueueDepth];
  logic [kpe_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [kpe_pkg::QPtrW:0]    cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign full_o  = (cnt_q == ($bits(cnt_q))'(kpe_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> src/kpe_back.sv
// Output stage: turns each queued outcome into one or two result requests.
module kpe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  kpe_pkg::q_entry_t  q_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [63:0]        pmkid_upper_o,
  output logic [63:0]        pmkid_lower_o,
  output logic [11:0]        pmkid_count_o,
  output logic               truncated_o
);

  logic        pv_q, pv_d;
  logic        sv_q, sv_d;
  logic [63:0] upper_q, lower_q;
  logic [11:0] count_q;
  logic        trunc_q;
  logic        take, slot_free;

  assign out_valid_o = pv_q | sv_q;
  assign take        = out_valid_o & out_ready_i;
  // The slot frees when empty or when its only remaining result leaves.
  assign slot_free   = !out_valid_o || (take && !(pv_q && sv_q));
  assign pop_o       = slot_free && q_valid_i;

  always_comb begin
    pv_d = pv_q;
    sv_d = sv_q;
    if (pop_o) begin
      pv_d = q_head_i.pmkid_valid;
      sv_d = q_head_i.summary_valid;
    end else if (take) begin
      if (pv_q) begin
        pv_d = 1'b0;
      end else begin
        sv_d = 1'b0;
      end
    end else if (slot_free) begin
      pv_d = 1'b0;
      sv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      upper_q <= q_head_i.upper;
      lower_q <= q_head_i.lower;
      count_q <= q_head_i.count;
      trunc_q <= q_head_i.truncated;
    end
  end

  assign result_kind_o = ~pv_q;
  assign pmkid_upper_o = pv_q ? upper_q : 64'd0;
  assign pmkid_lower_o = pv_q ? lower_q : 64'd0;
  assign pmkid_count_o = count_q;
  assign truncated_o   = pv_q ? 1'b0 : trunc_q;

endmodule

>>> src/kde_pmkid_extractor.sv
// Top level of the EAPOL-Key key data PMKID extractor.
//
// Key data enters one byte per request on the input channel, with last_byte
// marking the final byte of a buffer and key_data_encrypted suppressing
// PMKID reports. Each request on the output channel is either a PMKID
// (result_kind 0, sixteen bytes split over pmkid_upper and pmkid_lower) or
// the end-of-buffer summary (result_kind 1) with the saturating PMKID count
// and the truncation flag. A byte that completes a PMKID element and also
// ends the buffer yields the PMKID request first, then the summary.
// The parser takes one byte per cycle while the outcome queue is not full.
// A result passes from the byte that causes it into the four-entry outcome
// queue and then into the output register. A byte that yields two results
// holds the output register for two accepted requests. When the receiver
// stalls, the queue absorbs outcomes and in_ready_o drops only once the
// queue is full. Reset clears the parser and output state and restores the
// register defaults (type 0xDD, OUI 00-0F-AC, data type 4). Configuration
// writes are always accepted and take effect in the next cycle.
module kde_pmkid_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        key_data_encrypted_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [63:0] pmkid_upper_o,
  output logic [63:0] pmkid_lower_o,
  output logic [11:0] pmkid_count_o,
  output logic        truncated_o
);

  // Parser to queue.
  logic              push;
  kpe_pkg::q_entry_t entry;
  logic              q_full;

  // Queue to output stage.
  logic              q_valid;
  kpe_pkg::q_entry_t q_head;
  logic              pop;

  kpe_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .data_byte_i          (data_byte_i),
    .last_byte_i          (last_byte_i),
    .key_data_encrypted_i (key_data_encrypted_i),
    .q_full_i             (q_full),
    .push_o               (push),
    .entry_o              (entry)
  );

  kpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (pop)
  );

  kpe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .pmkid_upper_o (pmkid_upper_o),
    .pmkid_lower_o (pmkid_lower_o),
    .pmkid_count_o (pmkid_count_o),
    .truncated_o   (truncated_o)
  );

`ifndef NO_ASSERTIONS
  // The parser never pushes an outcome into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("outcome pushed into a full queue");

  // A reported PMKID is counted and never flagged as truncated.
  a_pmkid_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |-> (pmkid_count_o != 12'd0 && !truncated_o))
    else $error("PMKID result with zero count or truncation flag");

  // A PMKID that is taken while its summary waits is followed by the summary.
  a_summary_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !result_kind_o && u_back.sv_q)
      |=> (out_valid_o && result_kind_o))
    else $error("summary lost after a PMKID on the last byte");
`endif

endmodule
